// ===== hdl/eau_pkg.sv =====
// Shared types and constants for the execute stage ALU with address unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package eau_pkg;
    localparam int DATA_WIDTH  = 64;
    localparam int HALF_WIDTH  = DATA_WIDTH / 2;
    localparam int SHIFT_AMT   = 32;
    localparam int DIV_STEPS   = DATA_WIDTH;

    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_SUB      = 4'd1;
    localparam logic [3:0] OP_SHUTDOWN = 4'd2;
    localparam logic [3:0] OP_NOP      = 4'd3;
    localparam logic [3:0] OP_DEBUG    = 4'd4;
    localparam logic [3:0] OP_MUL_ADD  = 4'd5;
    localparam logic [3:0] OP_DIV_ADD  = 4'd6;
    localparam logic [3:0] OP_LOAD     = 4'd7;
    localparam logic [3:0] OP_STORE    = 4'd8;

    localparam logic [7:0] MODE_DIRECT  = 8'd0;
    localparam logic [7:0] MODE_BASE    = 8'd1;
    localparam logic [7:0] MODE_SHIFTED = 8'd2;

    typedef logic [DATA_WIDTH-1:0] t_word;

    // Fields that ride along the divider pipeline
    typedef struct packed {
        t_word res_pre;
        t_word imm;
        t_word addr;
        logic  is_div;
        logic  fwd;
        logic  down;
        logic  bad_op;
        logic  dz;
        logic  bad_mode;
    } t_side;

    typedef struct packed {
        t_word rem;
        t_word dvd;
        t_word dsr;
        t_word quo;
        t_side side;
    } t_div;
endpackage
`default_nettype wire

// ===== hdl/eau_div_step.sv =====
// One restoring-division step: produces one quotient bit per stage.
// Depends on eau_pkg.
`default_nettype none
module eau_div_step (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  eau_pkg::t_div      i_data,
    output logic               o_valid,
    output eau_pkg::t_div      o_data
);
    import eau_pkg::*;

    logic                r_valid;
    t_div                r_data;
    t_div                n_data;
    logic [DATA_WIDTH:0] w_trial;
    logic [DATA_WIDTH:0] w_diff;

    always_comb begin
        w_trial = {i_data.rem, i_data.dvd[DATA_WIDTH-1]};
        w_diff  = w_trial - {1'b0, i_data.dsr};
        n_data  = i_data;
        n_data.dvd = {i_data.dvd[DATA_WIDTH-2:0], 1'b0};
        // b of zero always subtracts, giving an all-ones quotient
        if (!w_diff[DATA_WIDTH]) begin
            n_data.rem = w_diff[DATA_WIDTH-1:0];
            n_data.quo = {i_data.quo[DATA_WIDTH-2:0], 1'b1};
        end else begin
            n_data.rem = w_trial[DATA_WIDTH-1:0];
            n_data.quo = {i_data.quo[DATA_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

// ===== hdl/execute_stage_alu_with_address_unit_core.sv =====
// Execute stage: ALU, address unit, pipelined multiplier and divider.
// Pipeline: 2 front stages, 64 divide steps, output register.
// Throughput one transaction per cycle; a stalled output freezes the pipe.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
// Depends on eau_pkg and eau_div_step.
`default_nettype none
module execute_stage_alu_with_address_unit_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [3:0]                  i_command,
    input  wire logic [7:0]                  i_function_code,
    input  wire logic [eau_pkg::DATA_WIDTH-1:0] i_operand_a,
    input  wire logic [eau_pkg::DATA_WIDTH-1:0] i_operand_b,
    input  wire logic [eau_pkg::DATA_WIDTH-1:0] i_immediate_value,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [eau_pkg::DATA_WIDTH-1:0]   o_alu_result,
    output logic                             o_forward_enable,
    output logic                             o_shutdown_request,
    output logic [eau_pkg::DATA_WIDTH-1:0]   o_effective_address,
    output logic                             o_bad_address_mode,
    output logic                             o_bad_opcode,
    output logic                             o_divide_by_zero
);
    import eau_pkg::*;

    logic w_en;

    // stage A: operands and partial products
    logic                  r_va;
    logic [3:0]            r_cmd;
    logic [7:0]            r_mode;
    t_word                 r_a, r_b, r_imm;
    t_word                 r_p0;
    logic [HALF_WIDTH-1:0] r_p1, r_p2;

    // stage B: decoded, divider input
    logic  r_vb;
    t_div  r_db;
    t_div  n_db;
    t_word w_mul;
    t_word w_bimm;

    logic  w_v  [DIV_STEPS+1];
    t_div  w_d  [DIV_STEPS+1];

    // output register
    logic  r_vo;
    t_side r_so;
    t_word r_res;

    assign w_en    = !(r_vo && i_stall);
    assign o_stall = r_vo && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vo <= 1'b0;
        end else if (w_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vo <= w_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cmd  <= i_command;
            r_mode <= i_function_code;
            r_a    <= i_operand_a;
            r_b    <= i_operand_b;
            r_imm  <= i_immediate_value;
            r_p0   <= {{HALF_WIDTH{1'b0}}, i_operand_a[HALF_WIDTH-1:0]} *
                      {{HALF_WIDTH{1'b0}}, i_operand_b[HALF_WIDTH-1:0]};
            r_p1   <= HALF_WIDTH'(i_operand_a[HALF_WIDTH-1:0] *
                                  i_operand_b[DATA_WIDTH-1:HALF_WIDTH]);
            r_p2   <= HALF_WIDTH'(i_operand_a[DATA_WIDTH-1:HALF_WIDTH] *
                                  i_operand_b[HALF_WIDTH-1:0]);
        end
    end

    always_comb begin
        w_mul  = r_p0 + {r_p1 + r_p2, {HALF_WIDTH{1'b0}}};
        w_bimm = r_b + r_imm;
        n_db   = '0;
        n_db.rem = '0;
        n_db.dvd = r_a;
        n_db.dsr = r_b;
        n_db.quo = '0;
        n_db.side.imm = r_imm;
        n_db.side.dz  = (r_cmd == OP_DIV_ADD) && (r_b == '0);
        unique case (r_cmd)
            OP_ADD: begin
                n_db.side.res_pre = r_a + w_bimm;
                n_db.side.fwd     = 1'b1;
            end
            OP_SUB: begin
                n_db.side.res_pre = r_a - w_bimm;
                n_db.side.fwd     = 1'b1;
            end
            OP_SHUTDOWN: begin
                n_db.side.fwd  = 1'b1;
                n_db.side.down = 1'b1;
            end
            OP_NOP, OP_DEBUG: begin
                n_db.side.fwd = 1'b1;
            end
            OP_MUL_ADD: begin
                n_db.side.res_pre = w_mul + r_imm;
                n_db.side.fwd     = 1'b1;
            end
            OP_DIV_ADD: begin
                n_db.side.is_div = 1'b1;
                n_db.side.fwd    = 1'b1;
            end
            OP_LOAD: begin
                n_db.side.res_pre = '0;
            end
            OP_STORE: begin
                n_db.side.res_pre = r_b;
            end
            default: begin
                n_db.side.bad_op = 1'b1;
            end
        endcase
        unique case (r_mode)
            MODE_DIRECT:  n_db.side.addr = r_imm;
            MODE_BASE:    n_db.side.addr = r_a + r_imm;
            MODE_SHIFTED: n_db.side.addr = (r_a << SHIFT_AMT) + r_imm;
            default: begin
                n_db.side.addr     = '1;
                n_db.side.bad_mode = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_db <= n_db;
        end
    end

    assign w_v[0] = r_vb;
    assign w_d[0] = r_db;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        eau_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[g]),
            .i_data  (w_d[g]),
            .o_valid (w_v[g+1]),
            .o_data  (w_d[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_so  <= w_d[DIV_STEPS].side;
            r_res <= w_d[DIV_STEPS].side.is_div ?
                     w_d[DIV_STEPS].quo + w_d[DIV_STEPS].side.imm :
                     w_d[DIV_STEPS].side.res_pre;
        end
    end

    assign o_valid             = r_vo;
    assign o_alu_result        = r_res;
    assign o_forward_enable    = r_so.fwd;
    assign o_shutdown_request  = r_so.down;
    assign o_effective_address = r_so.addr;
    assign o_bad_address_mode  = r_so.bad_mode;
    assign o_bad_opcode        = r_so.bad_op;
    assign o_divide_by_zero    = r_so.dz;

    a_badop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && r_so.bad_op) |-> (r_res == '0 && !r_so.fwd && !r_so.down))
        else $error("bad opcode result not quiet");
    a_dz_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && r_so.dz) |-> (r_so.is_div && r_so.fwd && !r_so.bad_op))
        else $error("divide by zero flag on non-divide");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && i_stall) |=> (r_vo && $stable(r_res) && $stable(r_so)))
        else $error("output changed under stall");
    a_badmode_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && r_so.bad_mode) |-> (r_so.addr == '1))
        else $error("bad mode address not all ones");
endmodule
`default_nettype wire
